FILE: hw/rtl/vtaep_pkg.sv
package vtaep_pkg;

    typedef enum logic [3:0] {
        PH_SEARCH  = 4'd0,
        PH_TDCH_LO = 4'd1,
        PH_TDCH_HI = 4'd2,
        PH_TDC_LO  = 4'd3,
        PH_TDC_HI  = 4'd4,
        PH_EOB_LO  = 4'd5,
        PH_EOB_HI  = 4'd6,
        PH_ADCH_LO = 4'd7,
        PH_ADCH_HI = 4'd8,
        PH_ADC_LO  = 4'd9,
        PH_ADC_HI  = 4'd10
    } t_phase;

    localparam logic       KIND_HIT         = 1'b0;
    localparam logic       KIND_DONE        = 1'b1;
    localparam logic [15:0] EVENT_MARKER_RST = 16'h004C;

    typedef struct packed {
        logic        kind;
        logic [4:0]  geo_address;
        logic [4:0]  channel;
        logic [11:0] amplitude;
        logic [31:0] event_number;
        logic        last;
    } t_result;

    // results produced by one halfword: none, one, or a hit followed by event done
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

FILE: hw/rtl/vtaep_parse.sv
module vtaep_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_accept,
    input  logic [15:0]      i_halfword,
    input  logic [15:0]      i_event_marker,
    output vtaep_pkg::t_push o_push
);
    import vtaep_pkg::*;

    logic        r_in_valid;
    logic [15:0] r_in_hw;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [15:0] r_low_half;
    logic [15:0] n_low_half;
    logic [5:0]  r_words_left;
    logic [5:0]  n_words_left;
    logic [31:0] r_event_count;
    logic [31:0] n_event_count;
    logic [5:0]  w_cnt_dec;
    logic [5:0]  w_hdr_cnt;

    assign w_cnt_dec = r_words_left - 6'd1;
    // count sits in bits 13:8 of the word, i.e. in the low halfword
    assign w_hdr_cnt = r_low_half[13:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_phase       <= PH_SEARCH;
            r_low_half    <= '0;
            r_words_left  <= '0;
            r_event_count <= '0;
        end else begin
            r_in_valid    <= i_in_accept;
            r_phase       <= n_phase;
            r_low_half    <= n_low_half;
            r_words_left  <= n_words_left;
            r_event_count <= n_event_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_in_hw <= i_halfword;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_low_half    = r_low_half;
        n_words_left  = r_words_left;
        n_event_count = r_event_count;
        if (r_in_valid) begin
            unique case (r_phase)
                PH_TDCH_LO, PH_TDC_LO, PH_EOB_LO, PH_ADCH_LO, PH_ADC_LO: begin
                    n_low_half = r_in_hw;
                    n_phase    = t_phase'(r_phase + 4'd1);
                end
                PH_TDCH_HI: begin
                    n_words_left = w_hdr_cnt;
                    n_phase      = (w_hdr_cnt == '0) ? PH_EOB_LO : PH_TDC_LO;
                end
                PH_TDC_HI: begin
                    n_words_left = w_cnt_dec;
                    n_phase      = (w_cnt_dec == '0) ? PH_EOB_LO : PH_TDC_LO;
                end
                PH_EOB_HI: begin
                    n_phase = PH_ADCH_LO;
                end
                PH_ADCH_HI: begin
                    n_words_left = w_hdr_cnt;
                    n_phase      = (w_hdr_cnt == '0) ? PH_SEARCH : PH_ADC_LO;
                end
                PH_ADC_HI: begin
                    n_words_left = w_cnt_dec;
                    n_phase      = (w_cnt_dec == '0) ? PH_SEARCH : PH_ADC_LO;
                end
                default: begin
                    // searching, unused codes fall back here as well
                    n_phase = PH_SEARCH;
                    if (r_in_hw == i_event_marker) begin
                        n_event_count = r_event_count + 32'd1;
                        n_phase       = PH_TDCH_LO;
                    end
                end
            endcase
        end
    end

    always_comb begin
        t_result w_hit;
        t_result w_done;
        w_hit.kind         = KIND_HIT;
        w_hit.geo_address  = r_in_hw[15:11];
        w_hit.channel      = r_in_hw[4:0];
        w_hit.amplitude    = r_low_half[11:0];
        w_hit.event_number = r_event_count;
        w_hit.last         = 1'b0;
        w_done.kind         = KIND_DONE;
        w_done.geo_address  = '0;
        w_done.channel      = '0;
        w_done.amplitude    = '0;
        w_done.event_number = r_event_count;
        w_done.last         = 1'b1;
        o_push     = '0;
        o_push.r0  = w_hit;
        o_push.r1  = w_done;
        if (r_in_valid) begin
            unique case (r_phase)
                PH_ADCH_HI: begin
                    if (w_hdr_cnt == '0) begin
                        o_push.cnt = 2'd1;
                        o_push.r0  = w_done;
                    end
                end
                PH_ADC_HI: begin
                    o_push.cnt = (w_cnt_dec == '0) ? 2'd2 : 2'd1;
                end
                default: begin
                    o_push.cnt = 2'd0;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/vtaep_result_fifo.sv
module vtaep_result_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  vtaep_pkg::t_push         i_push,
    input  logic                     i_pop,
    output vtaep_pkg::t_result       o_head,
    output logic [$clog2(DEPTH):0]   o_count
);
    import vtaep_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   w_wr_ptr_1;

    assign w_wr_ptr_1 = r_wr_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wr_ptr_1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(i_pop);
            r_count  <= r_count + CNT_W'(i_push.cnt) - CNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

FILE: hw/rtl/vme_tdc_adc_event_parser.sv
// Readout event parser: takes one 16-bit halfword per cycle unless stalled (low half of
// each 32-bit word first), finds the event marker, steps over the TDC block and
// end-of-block word, and returns one result per ADC data word plus an event-done result
// carrying the event number. A halfword is held in the input register and its results
// are then written to the buffer, whose head drives the output. Results queue in a
// RESULT_DEPTH-entry buffer (power of two, at least 4); input stall rises only when more
// than RESULT_DEPTH-4 results wait, so with a free-running output the block takes one
// halfword every cycle. The marker register is written through the config port, which is
// always ready.
module vme_tdc_adc_event_parser #(
    parameter int RESULT_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_halfword,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [4:0]  o_geo_address,
    output logic [4:0]  o_channel,
    output logic [11:0] o_amplitude,
    output logic [31:0] o_event_number,
    output logic        o_last
);
    import vtaep_pkg::*;

    localparam int CNT_W = $clog2(RESULT_DEPTH) + 1;

    logic [15:0]      r_event_marker;
    logic             w_in_accept;
    logic             w_pop;
    t_push            w_push;
    t_result          w_head;
    logic [CNT_W-1:0] w_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_marker <= EVENT_MARKER_RST;
        end else if (i_cfg_valid) begin
            r_event_marker <= i_cfg_data;
        end
    end

    // room for the item in flight and the new one, two results each
    assign o_in_stall  = (w_count > CNT_W'(RESULT_DEPTH - 4));
    assign w_in_accept = i_in_valid & ~o_in_stall;
    assign o_out_valid = (w_count != '0);
    assign w_pop       = o_out_valid & ~i_out_stall;

    vtaep_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_accept    (w_in_accept),
        .i_halfword     (i_halfword),
        .i_event_marker (r_event_marker),
        .o_push         (w_push)
    );

    vtaep_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_count (w_count)
    );

    assign o_kind         = w_head.kind;
    assign o_geo_address  = w_head.geo_address;
    assign o_channel      = w_head.channel;
    assign o_amplitude    = w_head.amplitude;
    assign o_event_number = w_head.event_number;
    assign o_last         = w_head.last;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(RESULT_DEPTH))
        else $error("result queue overflow");

    a_pair_ends_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt == 2'd2) |-> (w_push.r1.last && w_push.r1.kind == KIND_DONE
                                  && w_push.r0.kind == KIND_HIT))
        else $error("double push not a hit followed by event done");

    a_last_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind == KIND_DONE)))
        else $error("last flag disagrees with result kind");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_push.cnt == 2'd0) |=> (w_count == $past(w_count) - CNT_W'(1)))
        else $error("queue count did not follow a delivered transaction");
`endif

endmodule
